/* rtl/core/pgc_pkg.sv */
package pgc_pkg;

  localparam int DATA_W              = 8;
  localparam int IDX_W               = 8;
  localparam int GAIN_W              = 10;
  localparam int FRAC_W              = 8;
  localparam int ENTRY_W             = 3 * DATA_W;
  localparam int PROD_W              = DATA_W + GAIN_W;
  localparam int OP_W                = 2;
  localparam int CFG_IDX_W           = 2;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_RED_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_GAIN  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_ROTATE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT_SAVE,
    S_ROT_SHIFT,
    S_ROT_LAST,
    S_LK_MUL,
    S_LK_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_ENTRY,
    RD_LAST,
    RD_PTR_DEC
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_INPUT,
    WR_FIRST_RDATA,
    WR_SHIFT,
    WR_FIRST_SAVED
  } wr_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ptr_load;
    logic    ptr_dec;
    logic    save_en;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    mul_en;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic entry_ok;
    logic last_ok;
    logic ptr_gt_first;
    logic out_busy;
  } status_t;

  function automatic logic [DATA_W-1:0] saturate(input logic [PROD_W-1:0] p);
    logic [DATA_W-1:0] r;
    if (p[PROD_W-1:DATA_W+FRAC_W] != '0) begin
      r = '1;
    end else begin
      r = p[DATA_W+FRAC_W-1:FRAC_W];
    end
    return r;
  endfunction

endpackage

/* rtl/core/pgc_req_if.sv */
interface pgc_req_if;
  import pgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  entry_index;
  logic [IDX_W-1:0]  last_index;
  logic [DATA_W-1:0] red_in;
  logic [DATA_W-1:0] green_in;
  logic [DATA_W-1:0] blue_in;

  modport source (
    output valid, operation, entry_index, last_index, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, last_index, red_in, green_in, blue_in,
    output ready
  );
endinterface

/* rtl/core/pgc_rsp_if.sv */
interface pgc_rsp_if;
  import pgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  looked_up_index;
  logic [DATA_W-1:0] red_out;
  logic [DATA_W-1:0] green_out;
  logic [DATA_W-1:0] blue_out;

  modport source (
    output valid, looked_up_index, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, looked_up_index, red_out, green_out, blue_out,
    output ready
  );
endinterface

/* rtl/core/pgc_cfg_if.sv */
interface pgc_cfg_if;
  import pgc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* rtl/core/pgc_ctrl.sv */
module pgc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  pgc_pkg::status_t  status,
  output pgc_pkg::cmd_t     cmd
);
  import pgc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.rd_sel   = RD_ENTRY;
    cmd.wr_sel   = WR_INPUT;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          case (status.op)
            OP_WRITE: begin
              if (status.entry_ok) begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_INPUT;
              end
            end
            OP_ROTATE: begin
              if (status.entry_ok && status.last_ok) begin
                cmd.capture  = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_LAST;
                cmd.ptr_load = 1'b1;
                state_next   = S_ROT_SAVE;
              end
            end
            OP_LOOKUP: begin
              cmd.capture = 1'b1;
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RD_ENTRY;
              state_next  = S_LK_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROT_SAVE: begin
        cmd.save_en = 1'b1;
        if (status.ptr_gt_first) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PTR_DEC;
          cmd.ptr_dec = 1'b1;
          state_next  = S_ROT_SHIFT;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_FIRST_RDATA;
          state_next = S_IDLE;
        end
      end
      S_ROT_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        if (status.ptr_gt_first) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PTR_DEC;
          cmd.ptr_dec = 1'b1;
        end else begin
          state_next = S_ROT_LAST;
        end
      end
      S_ROT_LAST: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_FIRST_SAVED;
        state_next = S_IDLE;
      end
      S_LK_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_LK_OUT;
      end
      S_LK_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/pgc_datapath.sv */
module pgc_datapath #(
  parameter int PALETTE_ENTRIES = pgc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pgc_req_if.sink           req,
  pgc_rsp_if.source         rsp,
  pgc_cfg_if.sink           cfg,
  input  pgc_pkg::cmd_t     cmd,
  output pgc_pkg::status_t  status
);
  import pgc_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(PALETTE_ENTRIES);

  logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];

  logic [GAIN_W-1:0]  red_gain;
  logic [GAIN_W-1:0]  green_gain;
  logic [GAIN_W-1:0]  blue_gain;

  logic [AW-1:0]      first;
  logic [AW-1:0]      ptr;
  logic [IDX_W-1:0]   lk_index;
  logic               lk_ok;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] saved;
  logic [PROD_W-1:0]  red_prod;
  logic [PROD_W-1:0]  green_prod;
  logic [PROD_W-1:0]  blue_prod;

  logic               out_valid;
  logic [IDX_W-1:0]   out_index;
  logic [DATA_W-1:0]  red_q;
  logic [DATA_W-1:0]  green_q;
  logic [DATA_W-1:0]  blue_q;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               entry_ok;
  logic               last_ok;

  assign entry_ok = ({1'b0, req.entry_index} < DEPTH);
  assign last_ok  = ({1'b0, req.last_index} < DEPTH);

  // gain registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain   <= GAIN_RESET;
      green_gain <= GAIN_RESET;
      blue_gain  <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RED_GAIN:   red_gain   <= cfg.data;
        CFG_GREEN_GAIN: green_gain <= cfg.data;
        CFG_BLUE_GAIN:  blue_gain  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // address and data selection
  always_comb begin
    case (cmd.rd_sel)
      RD_ENTRY:   raddr = req.entry_index[AW-1:0];
      RD_LAST:    raddr = req.last_index[AW-1:0];
      RD_PTR_DEC: raddr = ptr - AW'(1);
      default:    raddr = ptr;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_INPUT: begin
        waddr = req.entry_index[AW-1:0];
        wdata = {req.red_in, req.green_in, req.blue_in};
      end
      WR_FIRST_RDATA: begin
        waddr = first;
        wdata = rdata;
      end
      WR_SHIFT: begin
        waddr = ptr + AW'(1);
        wdata = rdata;
      end
      WR_FIRST_SAVED: begin
        waddr = first;
        wdata = saved;
      end
      default: begin
        waddr = first;
        wdata = rdata;
      end
    endcase
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // request fields and rotate pointer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      first    <= req.entry_index[AW-1:0];
      lk_index <= req.entry_index;
      lk_ok    <= entry_ok;
    end
    if (cmd.ptr_load) begin
      ptr <= req.last_index[AW-1:0];
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end
    if (cmd.save_en) begin
      saved <= rdata;
    end
  end

  // gain multiply
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (lk_ok) begin
        red_prod   <= PROD_W'(rdata[3*DATA_W-1:2*DATA_W]) * PROD_W'(red_gain);
        green_prod <= PROD_W'(rdata[2*DATA_W-1:DATA_W]) * PROD_W'(green_gain);
        blue_prod  <= PROD_W'(rdata[DATA_W-1:0]) * PROD_W'(blue_gain);
      end else begin
        red_prod   <= '0;
        green_prod <= '0;
        blue_prod  <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= lk_index;
      red_q     <= saturate(red_prod);
      green_q   <= saturate(green_prod);
      blue_q    <= saturate(blue_prod);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.looked_up_index = out_index;
  assign rsp.red_out         = red_q;
  assign rsp.green_out       = green_q;
  assign rsp.blue_out        = blue_q;

  assign req.ready = cmd.in_ready;

  assign status.in_valid     = req.valid;
  assign status.op           = op_t'(req.operation);
  assign status.entry_ok     = entry_ok;
  assign status.last_ok      = last_ok;
  assign status.ptr_gt_first = (ptr > first);
  assign status.out_busy     = out_valid && !rsp.ready;

endmodule

/* rtl/core/palette_gain_and_cycling.sv */
// channel  role    handshake      contents
// req      sink    valid/ready    operation, entry_index, last_index, red/green/blue_in
// rsp      source  valid/ready    looked_up_index, red/green/blue_out
// cfg      sink    valid/ready    index (0 red, 1 green, 2 blue gain), data
//
// write: taken in the idle state; lookup: memory read, gain multiply, output load
// rotate: one entry moved per cycle on the single write port
// a lookup holds in its last step while the output register is still full
// rst is synchronous; gains reset to 1.0, palette contents undefined until written
module palette_gain_and_cycling #(
  parameter int PALETTE_ENTRIES = pgc_pkg::PALETTE_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  pgc_req_if.sink   req,
  pgc_rsp_if.source rsp,
  pgc_cfg_if.sink   cfg
);
  import pgc_pkg::*;

  cmd_t    cmd;
  status_t status;

  pgc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pgc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
